### sv/lruac_pkg.sv
// shared types and constants for the counter-based lru bookkeeping core
`timescale 1ns / 1ps
`default_nettype none

package lruac_pkg;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_CLEAR      = 2'd0;
    localparam opcode_t OP_WRITE_LINE = 2'd1;
    localparam opcode_t OP_TOUCH      = 2'd2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW
    } state_t;

endpackage

`default_nettype wire

### sv/lruac_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lruac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/lru_age_counter_update_core.sv
// top level of the counter-based lru age, tag and valid bookkeeping core
//
// usage
//   s_ channel: one command per transaction (clear, write_line, touch, or a
//   no-op code); m_ channel: one result per command with the hit flag and
//   the lowest matching way of a touch, both zero for every other command.
//   state lives in two rams indexed by set: one row of tags and one row of
//   valid bits plus age counters. for write_line, touch and the no-op the
//   set row is read in the accept cycle; in the next cycle the modified row
//   is written back (the no-op writes nothing) and the result is produced.
//   a clear sweeps the valid/age ram one set a cycle; its result is produced
//   in the last sweep step, and the next command is taken after the sweep.
//   after reset the same sweep runs with s_tready low.
//   results go through an output register backed by one skid entry, so a
//   new command is taken while a result waits; when both are full because
//   the receiver stalls, s_tready drops until m_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module lru_age_counter_update_core #(
    parameter int WAYS     = 4,
    parameter int SETS     = 64,
    parameter int TAG_BITS = 20
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // opcode[1:0], set_index[7:2], way[9:8], tag[29:10], valid_value[30],
    // old_age[32:31], zero fill above
    input  wire logic [lruac_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // hit[0], hit_way[2:1], zero fill above
    output logic      [lruac_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready
);

    import lruac_pkg::*;

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AGE_W  = $clog2(WAYS);
    localparam int META_W = WAYS * (AGE_W + 1);
    localparam int TROW_W = WAYS * TAG_BITS;

    typedef struct packed {
        logic [WAYS-1:0][AGE_W-1:0] age;
        logic [WAYS-1:0]            vld;
    } meta_row_t;

    typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;

    // input fields
    opcode_t     s_opcode;
    logic [5:0]  s_set_index;
    logic [1:0]  s_way;
    logic [19:0] s_tag;
    logic        s_valid_value;
    logic [1:0]  s_old_age;

    assign s_opcode      = s_tdata[1:0];
    assign s_set_index   = s_tdata[7:2];
    assign s_way         = s_tdata[9:8];
    assign s_tag         = s_tdata[29:10];
    assign s_valid_value = s_tdata[30];
    assign s_old_age     = s_tdata[32:31];

    // set index modulo SETS as a constant table
    logic [SET_W-1:0] set_lut [64];

    for (genvar i = 0; i < 64; i++) begin : g_set_lut
        assign set_lut[i] = SET_W'(i % SETS);
    end

    state_t           state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_op_reg, clr_op_next;

    opcode_t          op_reg;
    logic [SET_W-1:0] set_reg;
    logic [1:0]       way_reg;
    logic [19:0]      tag_reg;
    logic             vv_reg;
    logic [1:0]       old_age_reg;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [1:0]       out_way_reg;
    logic             pend_valid_reg;
    logic             pend_hit_reg;
    logic [1:0]       pend_way_reg;

    logic             s_fire;
    logic             out_free;
    logic             res_fire;
    logic             res_hit;
    logic [1:0]       res_way;

    logic             meta_we;
    logic [SET_W-1:0] meta_waddr;
    meta_row_t        meta_wdata;
    meta_row_t        meta_rdata;
    logic             tag_we;
    tag_row_t         tag_wdata;
    tag_row_t         tag_rdata;
    logic [SET_W-1:0] rd_addr;

    meta_row_t        clr_row;
    meta_row_t        mod_meta;
    tag_row_t         mod_tag;
    logic             mod_hit;
    logic [1:0]       mod_way;
    logic             way_ok;

    assign s_tready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_addr  = set_lut[s_set_index];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3){1'b0}}, out_way_reg, out_hit_reg};

    lruac_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (s_fire),
        .raddr (rd_addr),
        .rdata (meta_rdata)
    );

    lruac_ram #(
        .WIDTH (TROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (set_reg),
        .wdata (tag_wdata),
        .re    (s_fire),
        .raddr (rd_addr),
        .rdata (tag_rdata)
    );

    // row modification for write_line and touch
    always_comb begin
        clr_row  = '0;
        mod_meta = meta_rdata;
        mod_tag  = tag_rdata;
        mod_hit  = 1'b0;
        mod_way  = 2'd0;
        way_ok   = (32'(way_reg) < 32'(WAYS));
        for (int w = 0; w < WAYS; w++) begin
            clr_row.age[w] = AGE_W'(WAYS - 1);
        end
        if (op_reg == OP_WRITE_LINE) begin
            for (int w = 0; w < WAYS; w++) begin
                if (32'(way_reg) == 32'(w)) begin
                    mod_meta.vld[w] = vv_reg;
                    mod_tag[w]      = TAG_BITS'(tag_reg);
                end
            end
        end else begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (meta_rdata.vld[w] && (tag_rdata[w] == TAG_BITS'(tag_reg))) begin
                    mod_meta.age[w] = '0;
                    mod_hit         = 1'b1;
                    mod_way         = 2'(w);
                end else if (32'(meta_rdata.age[w]) < 32'(old_age_reg)) begin
                    if (32'(meta_rdata.age[w]) + 32'd1 > 32'(WAYS - 1)) begin
                        mod_meta.age[w] = AGE_W'(WAYS - 1);
                    end else begin
                        mod_meta.age[w] = meta_rdata.age[w] + AGE_W'(1);
                    end
                end
            end
        end
    end

    // sequencer: clear sweep, idle, read-modify-write
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_op_next  = clr_op_reg;
        meta_we      = 1'b0;
        meta_waddr   = set_reg;
        meta_wdata   = mod_meta;
        tag_we       = 1'b0;
        tag_wdata    = mod_tag;
        res_fire     = 1'b0;
        res_hit      = 1'b0;
        res_way      = 2'd0;
        unique case (state_reg)
            ST_CLEAR: begin
                meta_we      = 1'b1;
                meta_waddr   = clr_cnt_reg;
                meta_wdata   = clr_row;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(SETS - 1)) begin
                    res_fire     = clr_op_reg;
                    clr_cnt_next = '0;
                    clr_op_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == OP_CLEAR) begin
                        clr_op_next = 1'b1;
                        state_next  = ST_CLEAR;
                    end else begin
                        state_next  = ST_RMW;
                    end
                end
            end
            ST_RMW: begin
                res_fire   = 1'b1;
                state_next = ST_IDLE;
                unique case (op_reg)
                    OP_WRITE_LINE: begin
                        meta_we = way_ok;
                        tag_we  = way_ok;
                    end
                    OP_TOUCH: begin
                        meta_we = 1'b1;
                        res_hit = mod_hit;
                        res_way = mod_way;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_op_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            priority if (pend_valid_reg && out_free) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (res_fire) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    pend_valid_reg <= 1'b1;
                end
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end else begin
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg      <= s_opcode;
            set_reg     <= rd_addr;
            way_reg     <= s_way;
            tag_reg     <= s_tag;
            vv_reg      <= s_valid_value;
            old_age_reg <= s_old_age;
        end
        priority if (pend_valid_reg && out_free) begin
            out_hit_reg <= pend_hit_reg;
            out_way_reg <= pend_way_reg;
        end else if (res_fire) begin
            if (out_free) begin
                out_hit_reg <= res_hit;
                out_way_reg <= res_way;
            end else begin
                pend_hit_reg <= res_hit;
                pend_way_reg <= res_way;
            end
        end else begin
        end
    end

    // a new result never arrives while the skid entry is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |-> !pend_valid_reg)
        else $error("result produced while skid entry full");

    // the skid entry only holds data behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    // an accepted command is processed in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_RMW || state_reg == ST_CLEAR))
        else $error("accepted command not processed");

    // only a touch can report a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_fire && res_hit) |-> (state_reg == ST_RMW && op_reg == OP_TOUCH))
        else $error("hit reported for a command other than touch");

endmodule

`default_nettype wire
